// ===== design/fsp_pkg.sv =====
// fsp_pkg: shared types, codes and constants for the frame sequencer.
// Used by fsp_step, frame_sequencer_playback_modes_top and the testbench.
package fsp_pkg;

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0]  REG_PLAY_MODE      = 2'd0;
    localparam logic [1:0]  REG_FRAME_INTERVAL = 2'd1;
    localparam logic [1:0]  REG_FRAME_COUNT    = 2'd2;

    localparam logic [15:0] INTERVAL_RESET = 16'd100;

    typedef enum logic [1:0] {
        ITEM_ADVANCE   = 2'd0,
        ITEM_SET_FRAME = 2'd1,
        ITEM_SET_ANIM  = 2'd2
    } t_item_mode;

    typedef enum logic [2:0] {
        PLAY_LOOP  = 3'd0,
        PLAY_SHOT  = 3'd1,
        PLAY_BACK  = 3'd2,
        PLAY_STAY  = 3'd3,
        PLAY_OSC   = 3'd4
    } t_play_mode;

    typedef struct packed {
        logic [2:0]  play_mode;
        logic [15:0] frame_interval;
        logic [14:0] frame_count;
    } t_cfg;

    typedef struct packed {
        logic [15:0] frame;
        logic        back;
        logic [31:0] last_ms;
        logic        active;
        logic        animating;
    } t_seq_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [15:0] frame_value;
        logic        animating_value;
    } t_item;

    typedef struct packed {
        logic [15:0] current_frame;
        logic        active;
        logic        animating;
        logic        backward;
        logic        advanced;
    } t_result;

endpackage

// ===== design/fsp_if.sv =====
// Valid/ready channel interfaces for tick items and sequencer results.
// Standalone; no package dependency.
interface fsp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [31:0]        now_ms;
    logic signed [15:0] frame_value;
    logic               animating_value;

    modport source (output valid, mode, now_ms, frame_value, animating_value, input ready);
    modport sink   (input valid, mode, now_ms, frame_value, animating_value, output ready);
endinterface

interface fsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] current_frame;
    logic               active;
    logic               animating;
    logic               backward;
    logic               advanced;

    modport source (output valid, current_frame, active, animating, backward, advanced,
                    input ready);
    modport sink   (input valid, current_frame, active, animating, backward, advanced,
                    output ready);
endinterface

// ===== design/frame_sequencer_playback_modes_top.sv =====
// frame_sequencer_playback_modes_top: animation frame sequencer top level.
// Depends on fsp_pkg, fsp_if (fsp_in_if, fsp_out_if) and fsp_step.
//
// Usage:
//   i_in carries one transaction per item: an advance check with the current
//   time in ms, a frame load, or an animating-flag load. o_out returns one
//   transaction per item with the frame and flags after that item and
//   whether it advanced the frame.
//   The APB port holds play_mode (0x0), frame_interval (0x4) and
//   frame_count (0x8); write it only while the block is idle.
// Timing:
//   A result is registered in the result register, or in the skid register
//   while that one is held. Throughput is one item per cycle while
//   i_in.ready is high; the whole update (33-bit due-time compare, frame
//   step and mode select) sits in fsp_step ahead of the result register.
//   A two-entry output buffer (result register plus skid register) keeps
//   i_in.ready high while a single result waits; it drops only when both
//   entries are full.
// Reset:
//   i_rst_n is synchronous, active low. It restores the register defaults
//   (loop, 100 ms, zero frames), clears frame and time, sets active and
//   animating, and empties the output buffer.
module frame_sequencer_playback_modes_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fsp_in_if.sink                      i_in,
    fsp_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fsp_pkg::APB_AW-1:0]  paddr,
    input  logic [fsp_pkg::APB_DW-1:0]  pwdata,
    output logic [fsp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import fsp_pkg::*;

    t_cfg       r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_item      item;
    t_result    res;
    t_result    r_out;
    t_result    r_skid;
    logic       r_out_valid;
    logic       r_skid_valid;
    logic       adv;
    logic       in_fire;
    logic       out_fire;
    logic       cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.play_mode      <= PLAY_LOOP;
            r_cfg.frame_interval <= INTERVAL_RESET;
            r_cfg.frame_count    <= 15'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PLAY_MODE:      r_cfg.play_mode      <= pwdata[2:0];
                REG_FRAME_INTERVAL: r_cfg.frame_interval <= pwdata[15:0];
                REG_FRAME_COUNT:    r_cfg.frame_count    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PLAY_MODE:      prdata = {29'b0, r_cfg.play_mode};
            REG_FRAME_INTERVAL: prdata = {16'b0, r_cfg.frame_interval};
            REG_FRAME_COUNT:    prdata = {17'b0, r_cfg.frame_count};
            default:            prdata = '0;
        endcase
    end

    // item path
    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;
    assign out_fire   = r_out_valid && o_out.ready;

    assign item.mode            = i_in.mode;
    assign item.now_ms          = i_in.now_ms;
    assign item.frame_value     = i_in.frame_value;
    assign item.animating_value = i_in.animating_value;

    fsp_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_item     (item),
        .o_state    (n_state),
        .o_advanced (adv)
    );

    assign res.current_frame = n_state.frame;
    assign res.active        = n_state.active;
    assign res.animating     = n_state.animating;
    assign res.backward      = n_state.back;
    assign res.advanced      = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.frame     <= 16'd0;
            r_state.back      <= 1'b0;
            r_state.last_ms   <= 32'd0;
            r_state.active    <= 1'b1;
            r_state.animating <= 1'b1;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire || !r_out_valid) begin
                r_out_valid  <= r_skid_valid || in_fire;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (in_fire && r_out_valid && !out_fire) begin
            r_skid <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.current_frame = r_out.current_frame;
    assign o_out.active        = r_out.active;
    assign o_out.animating     = r_out.animating;
    assign o_out.backward      = r_out.backward;
    assign o_out.advanced      = r_out.advanced;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_adv_takes_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && adv) |=> (r_state.last_ms == $past(i_in.now_ms)))
        else $error("advance did not record the tick time");

    a_time_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_fire && adv) |=> $stable(r_state.last_ms))
        else $error("last advance time changed without an advance");

    a_bad_mode_no_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_cfg.play_mode > PLAY_OSC)) |=> $stable(r_state.back)
            && $stable(r_state.active))
        else $error("undefined play mode changed sequencer flags");

endmodule

// ===== design/fsp_step.sv =====
// fsp_step: next-state logic of the sequencer for one item.
// Depends on fsp_pkg.
module fsp_step (
    input  fsp_pkg::t_cfg       i_cfg,
    input  fsp_pkg::t_seq_state i_state,
    input  fsp_pkg::t_item      i_item,
    output fsp_pkg::t_seq_state o_state,
    output logic                o_advanced
);
    import fsp_pkg::*;

    logic [32:0] due;
    logic        time_ok;
    logic        mode_ok;
    logic        anim_ok;
    logic        adv;
    logic [15:0] stepped;
    logic [15:0] restep;
    logic        at_end;
    logic        at_low;

    always_comb begin
        due     = {1'b0, i_state.last_ms} + {17'b0, i_cfg.frame_interval};
        time_ok = due <= {1'b0, i_item.now_ms};
        mode_ok = i_cfg.play_mode <= PLAY_OSC;
        anim_ok = (i_cfg.play_mode == PLAY_LOOP) || i_state.animating;
        adv     = (t_item_mode'(i_item.mode) == ITEM_ADVANCE) && time_ok && mode_ok && anim_ok;
        stepped = i_state.frame + (i_state.back ? 16'hFFFF : 16'h0001);
        restep  = stepped + (i_state.back ? 16'h0001 : 16'hFFFF);
        at_end  = $signed(stepped) >= $signed({1'b0, i_cfg.frame_count});
        at_low  = $signed(stepped) <= $signed(16'sd0);
    end

    always_comb begin
        o_state    = i_state;
        o_advanced = adv;
        unique case (t_item_mode'(i_item.mode))
            ITEM_ADVANCE: begin
                if (adv) begin
                    o_state.last_ms = i_item.now_ms;
                    o_state.frame   = stepped;
                    unique case (t_play_mode'(i_cfg.play_mode))
                        PLAY_LOOP: begin
                            if (at_end) o_state.frame = 16'h0000;
                        end
                        PLAY_SHOT: begin
                            if (at_end) o_state.active = 1'b0;
                        end
                        PLAY_BACK: begin
                            if (at_end) begin
                                o_state.back      = !i_state.back;
                                o_state.animating = 1'b0;
                            end
                        end
                        PLAY_STAY: begin
                            if (at_end) begin
                                o_state.frame     = {1'b0, i_cfg.frame_count} - 16'd1;
                                o_state.animating = 1'b0;
                            end
                        end
                        PLAY_OSC: begin
                            if (at_end || at_low) begin
                                o_state.back  = !i_state.back;
                                o_state.frame = restep;
                            end
                        end
                        default: o_state = i_state;
                    endcase
                end
            end
            ITEM_SET_FRAME: o_state.frame     = i_item.frame_value;
            ITEM_SET_ANIM:  o_state.animating = i_item.animating_value;
            default:        o_state = i_state;
        endcase
    end

endmodule

// ===== test/fsp_sequence_checker.sv =====
`timescale 1ns / 100ps
// fsp_sequence_checker: watches the item, result and APB channels of the frame sequencer,
// predicts every result and compares it with what the block returns.
// Depends on fsp_pkg and fsp_if (fsp_in_if, fsp_out_if).
module fsp_sequence_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fsp_in_if                          i_in_mon,
    fsp_out_if                         i_out_mon,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [fsp_pkg::APB_AW-1:0] i_paddr,
    input  logic [fsp_pkg::APB_DW-1:0] i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_result_count,
    output int                         o_advance_count
);
    import fsp_pkg::*;

    localparam int REPORT_LIMIT = 40;

    logic [2:0]  cfg_play;
    logic [15:0] cfg_interval;
    logic [14:0] cfg_count;

    logic [15:0] seq_frame;
    logic        seq_back;
    logic [31:0] seq_last_ms;
    logic        seq_active;
    logic        seq_anim;

    t_result     expected_results[$];
    int          fail_total    = 0;
    int          result_total  = 0;
    int          advance_total = 0;

    function automatic logic [15:0] step_frame(input logic [15:0] frame, input logic back);
        return frame + (back ? 16'hFFFF : 16'h0001);
    endfunction

    // Applies one item to the shadow sequencer and returns the frame and flags after it.
    function automatic t_result sequence_step(input t_item item);
        t_result     res;
        logic [32:0] due;
        int          frame_s;
        logic        at_end;
        res.advanced = 1'b0;
        case (item.mode)
            ITEM_ADVANCE: begin
                due = {1'b0, seq_last_ms} + {17'b0, cfg_interval};
                if (cfg_play <= PLAY_OSC && due <= {1'b0, item.now_ms}
                    && (cfg_play == PLAY_LOOP || seq_anim)) begin
                    res.advanced = 1'b1;
                    seq_last_ms  = item.now_ms;
                    seq_frame    = step_frame(seq_frame, seq_back);
                    frame_s      = int'($signed(seq_frame));
                    at_end       = frame_s >= int'(cfg_count);
                    case (cfg_play)
                        PLAY_LOOP: if (at_end) seq_frame = '0;
                        PLAY_SHOT: if (at_end) seq_active = 1'b0;
                        PLAY_BACK: if (at_end) begin
                            seq_back = !seq_back;
                            seq_anim = 1'b0;
                        end
                        PLAY_STAY: if (at_end) begin
                            seq_frame = {1'b0, cfg_count} - 16'd1;
                            seq_anim  = 1'b0;
                        end
                        default: if (at_end || frame_s <= 0) begin
                            seq_back  = !seq_back;
                            seq_frame = step_frame(seq_frame, seq_back);
                        end
                    endcase
                end
            end
            ITEM_SET_FRAME: seq_frame = item.frame_value;
            ITEM_SET_ANIM:  seq_anim = item.animating_value;
            default: ;
        endcase
        res.current_frame = seq_frame;
        res.active        = seq_active;
        res.animating     = seq_anim;
        res.backward      = seq_back;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            if (fail_total < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, $signed(want), $signed(got));
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   item;
        t_result want;
        if (!i_rst_n) begin
            cfg_play     = PLAY_LOOP;
            cfg_interval = INTERVAL_RESET;
            cfg_count    = '0;
            seq_frame    = '0;
            seq_back     = 1'b0;
            seq_last_ms  = '0;
            seq_active   = 1'b1;
            seq_anim     = 1'b1;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_PLAY_MODE:      cfg_play = i_pwdata[2:0];
                    REG_FRAME_INTERVAL: cfg_interval = i_pwdata[15:0];
                    REG_FRAME_COUNT:    cfg_count = i_pwdata[14:0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                result_total++;
                if (expected_results.size() == 0) begin
                    if (fail_total < REPORT_LIMIT)
                        $display("%0t: unexpected transaction, expected none, actual frame %0d",
                                 $time, i_out_mon.current_frame);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("current_frame", want.current_frame, i_out_mon.current_frame);
                    check_field("active", 16'(want.active), 16'(i_out_mon.active));
                    check_field("animating", 16'(want.animating), 16'(i_out_mon.animating));
                    check_field("backward", 16'(want.backward), 16'(i_out_mon.backward));
                    check_field("advanced", 16'(want.advanced), 16'(i_out_mon.advanced));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                item.mode            = i_in_mon.mode;
                item.now_ms          = i_in_mon.now_ms;
                item.frame_value     = i_in_mon.frame_value;
                item.animating_value = i_in_mon.animating_value;
                want = sequence_step(item);
                if (want.advanced)
                    advance_total++;
                expected_results.push_back(want);
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= expected_results.size();
        o_result_count  <= result_total;
        o_advance_count <= advance_total;
    end

endmodule

// ===== test/tb_frame_sequencer_playback_modes_top.sv =====
`timescale 1ns / 100ps
// tb_frame_sequencer_playback_modes_top: clock, reset, APB setup and item traffic with
// random stalls for the frame sequencer; fsp_sequence_checker predicts and compares.
// Depends on fsp_pkg, fsp_if, fsp_sequence_checker and frame_sequencer_playback_modes_top.
module tb_frame_sequencer_playback_modes_top;
    import fsp_pkg::*;

    localparam int          HALF_PERIOD     = 5;
    localparam int          RESET_CYCLES    = 11;
    localparam int          RANDOM_ITEMS    = 1700;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam logic [1:0]  ITEM_RSVD       = 2'd3;
    localparam logic [2:0]  PLAY_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  PLAY_RSVD_LAST  = 3'd7;
    localparam logic [31:0] CLOCK_NEAR_WRAP = 32'hFFFF_FC00;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                frames_pending;
    int                result_count;
    int                advance_count;

    int                item_total  = 0;
    int                write_total = 0;
    int                cycle_count = 0;
    int                sink_hold   = 0;
    logic              src_calm    = 1'b0;
    logic              sink_calm   = 1'b0;
    logic [31:0]       clock_ms;
    logic [15:0]       stim_interval;
    logic [14:0]       stim_count;

    fsp_in_if  in_ch();
    fsp_out_if out_ch();

    frame_sequencer_playback_modes_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fsp_sequence_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (frames_pending),
        .o_result_count  (result_count),
        .o_advance_count (advance_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[frame_sequencer_playback_modes_top] ERROR");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure, with calm stretches.
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 149) == 0)
                sink_calm = !sink_calm;
            if ($urandom_range(0, 149) == 0)
                src_calm = !src_calm;
            if (sink_hold > 0) begin
                sink_hold--;
                out_ch.ready <= 1'b0;
            end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
                sink_hold = gap_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_item mk_item(input logic [1:0] mode, input logic [31:0] now,
                                      input logic [15:0] frame, input logic anim);
        t_item it;
        it.mode            = mode;
        it.now_ms          = now;
        it.frame_value     = frame;
        it.animating_value = anim;
        return it;
    endfunction

    // Mostly advance checks on a rising clock, plus loads, stale times and reserved items.
    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        logic [32:0] later;
        pick               = $urandom_range(0, 99);
        it.mode            = ITEM_ADVANCE;
        it.now_ms          = $urandom;
        it.frame_value     = 16'($urandom);
        it.animating_value = 1'($urandom_range(0, 1));
        if (pick < 70) begin
            if ($urandom_range(0, 9) == 0) begin
                it.now_ms = $urandom_range(0, clock_ms);
            end else begin
                later     = {1'b0, clock_ms} + $urandom_range(0, int'(stim_interval) * 3 / 2 + 3);
                clock_ms  = later[32] ? '1 : later[31:0];
                it.now_ms = clock_ms;
            end
        end else if (pick < 82) begin
            it.mode = ITEM_SET_FRAME;
            case ($urandom_range(0, 5))
                0: it.frame_value = 16'h8000;
                1: it.frame_value = 16'h7FFF;
                2: ;
                default: it.frame_value = 16'($urandom_range(0, int'(stim_count) + 1)) - 16'd1;
            endcase
        end else if (pick < 97) begin
            it.mode            = ITEM_SET_ANIM;
            it.animating_value = ($urandom_range(0, 3) != 0);
        end else begin
            it.mode = ITEM_RSVD;
        end
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int idle;
        if (!src_calm && $urandom_range(0, 3) == 0) begin
            idle = gap_len();
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.mode            <= it.mode;
        in_ch.now_ms          <= it.now_ms;
        in_ch.frame_value     <= it.frame_value;
        in_ch.animating_value <= it.animating_value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        item_total++;
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        write_total++;
        case (reg_idx)
            REG_FRAME_INTERVAL: stim_interval = value[15:0];
            REG_FRAME_COUNT:    stim_count = value[14:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (frames_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0]  play;
        logic [15:0] ival;
        logic [14:0] fcount;
        int          phase_len;
        int          random_sent;
        random_sent           = 0;
        clock_ms              = '0;
        stim_interval         = INTERVAL_RESET;
        stim_count            = '0;
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.mode            <= ITEM_ADVANCE;
        in_ch.now_ms          <= '0;
        in_ch.frame_value     <= '0;
        in_ch.animating_value <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: loop, 100 ms, zero frames.
        send_item(mk_item(ITEM_ADVANCE, 32'd0, 16'd0, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd100, 16'd0, 1'b0));
        send_item(mk_item(ITEM_RSVD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        send_item(mk_item(ITEM_SET_ANIM, 32'd0, 16'd0, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd250, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_FRAME, 32'd0, 16'h7FFF, 1'b0));
        wait_idle();
        apb_write(REG_PLAY_MODE, 32'(PLAY_SHOT));
        apb_write(REG_FRAME_INTERVAL, 32'd0);
        apb_write(REG_FRAME_COUNT, 32'h7FFF);
        send_item(mk_item(ITEM_ADVANCE, 32'hFFFF_FFFF, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_ANIM, 32'd0, 16'd0, 1'b1));
        send_item(mk_item(ITEM_ADVANCE, 32'd250, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_FRAME, 32'd0, 16'd32766, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd250, 16'd0, 1'b0));
        wait_idle();
        apb_write(REG_PLAY_MODE, 32'(PLAY_BACK));
        apb_write(REG_FRAME_COUNT, 32'd10);
        send_item(mk_item(ITEM_SET_FRAME, 32'd0, 16'd9, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd251, 16'd0, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd252, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_ANIM, 32'd0, 16'd0, 1'b1));
        send_item(mk_item(ITEM_ADVANCE, 32'd252, 16'd0, 1'b0));
        wait_idle();
        apb_write(REG_PLAY_MODE, 32'(PLAY_STAY));
        apb_write(REG_FRAME_COUNT, 32'd0);
        send_item(mk_item(ITEM_ADVANCE, 32'd253, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_ANIM, 32'd0, 16'd0, 1'b1));
        wait_idle();
        apb_write(REG_PLAY_MODE, 32'(PLAY_OSC));
        apb_write(REG_FRAME_COUNT, 32'd5);
        send_item(mk_item(ITEM_SET_FRAME, 32'd0, 16'd1, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd254, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_FRAME, 32'd0, 16'd4, 1'b0));
        send_item(mk_item(ITEM_ADVANCE, 32'd255, 16'd0, 1'b0));
        wait_idle();
        apb_write(REG_PLAY_MODE, 32'(PLAY_RSVD_FIRST));
        send_item(mk_item(ITEM_ADVANCE, 32'hFFFF_FFFF, 16'd0, 1'b0));
        send_item(mk_item(ITEM_SET_FRAME, 32'd0, 16'h8000, 1'b0));
        clock_ms = 32'd255;

        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            play = ($urandom_range(0, 9) == 0)
                 ? 3'($urandom_range(PLAY_RSVD_FIRST, PLAY_RSVD_LAST))
                 : 3'($urandom_range(PLAY_LOOP, PLAY_OSC));
            case ($urandom_range(0, 9))
                0:       ival = '0;
                1:       ival = 16'hFFFF;
                2:       ival = 16'($urandom);
                default: ival = 16'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 9))
                0:       fcount = '0;
                1:       fcount = 15'h7FFF;
                2:       fcount = 15'($urandom);
                default: fcount = 15'($urandom_range(1, 16));
            endcase
            apb_write(REG_PLAY_MODE, 32'(play));
            apb_write(REG_FRAME_INTERVAL, 32'(ival));
            apb_write(REG_FRAME_COUNT, 32'(fcount));
            // Last stretch runs the time base up against the 32-bit wrap.
            if (RANDOM_ITEMS - random_sent <= 200 && clock_ms < CLOCK_NEAR_WRAP)
                clock_ms = CLOCK_NEAR_WRAP;
            phase_len = $urandom_range(60, 140);
            if (phase_len > RANDOM_ITEMS - random_sent)
                phase_len = RANDOM_ITEMS - random_sent;
            repeat (phase_len) begin
                send_item(random_item());
                random_sent++;
            end
        end

        wait_idle();
        $display("run: %0d transactions in (%0d random), %0d results checked, %0d advances",
                 item_total, random_sent, result_count, advance_count);
        $display("run: %0d register writes over all play modes, interval and count extremes",
                 write_total);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("[frame_sequencer_playback_modes_top] OK");
        end else begin
            $display("[frame_sequencer_playback_modes_top] ERROR");
        end
        $finish;
    end

endmodule
